// ===== hdl/ltt_pkg.sv =====
// Shared constants, codes and types for the timer table.
`timescale 1ns / 1ps
package ltt_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);

  localparam logic [1:0] OP_REG   = 2'd0;
  localparam logic [1:0] OP_UNREG = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [2:0] KIND_REGISTERED = 3'd0;
  localparam logic [2:0] KIND_FULL       = 3'd1;
  localparam logic [2:0] KIND_UNREG      = 3'd2;
  localparam logic [2:0] KIND_FIRED      = 3'd3;
  localparam logic [2:0] KIND_IDLE       = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] ident;
    logic [31:0] period;
    logic [63:0] due_ms;
    logic        repeats;
  } slot_t;

endpackage

// ===== hdl/lazy_timer_table_core.sv =====
// Top level: timer list held in a slot RAM, scanned and compacted in place.
// Register: the slot is written when the word is taken; the result waits for a free port.
// Unregister and tick: armed slots are read one per cycle through the single RAM read port
// unless a stalled result port holds the scan. One item in progress at a time.
// Reset: time 0, empty list, next id 1. Slot RAM is not cleared; only slots
// below the armed count are ever read.
`timescale 1ns / 1ps
module lazy_timer_table_core
  import ltt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,  // delay_ms[31:0], periodic[32], target_id[64:33],
                                 // elapsed_ms[80:65], zero[87:81]
  input  logic [1:0]  in_tuser,  // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata, // timer_id[31:0]
  output logic [2:0]  out_tuser, // kind[2:0]
  output logic        out_tlast
);

  logic [31:0] in_delay;
  logic        in_periodic;
  logic [31:0] in_target;
  logic [15:0] in_elapsed;

  assign in_delay    = in_tdata[31:0];
  assign in_periodic = in_tdata[32];
  assign in_target   = in_tdata[64:33];
  assign in_elapsed  = in_tdata[80:65];

  state_t            state_r, state_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [63:0]       cur_ms_r, cur_ms_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [31:0]       fresh_r, fresh_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0]  keep_r, keep_nxt;
  logic [31:0]       target_r, target_nxt;
  logic [2:0]        resp_kind_r, resp_kind_nxt;
  logic [31:0]       resp_id_r, resp_id_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic [31:0]       pend_id_r, pend_id_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        out_kind_r, out_kind_nxt;
  logic [31:0]       out_id_r, out_id_nxt;
  logic              out_last_r, out_last_nxt;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  slot_t             ram_wdata;
  logic              ram_re;
  logic [SLOT_W-1:0] ram_raddr;
  logic [$bits(slot_t)-1:0] ram_rdata;
  slot_t             rd_slot;

  logic        out_free;
  logic        is_tick;
  logic        fire;
  logic        remove;
  logic        stall;
  logic [31:0] fresh_inc;
  logic [63:0] rearm_due;

  ltt_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (TIMER_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_slot   = slot_t'(ram_rdata);
  assign out_free  = !out_valid_r || out_tready;
  assign is_tick   = (op_r == OP_TICK);
  assign fresh_inc = fresh_r + 32'd1;
  assign rearm_due = cur_ms_r + {32'd0, rd_slot.period};

  always_comb begin
    fire   = is_tick && (rd_slot.due_ms <= cur_ms_r);
    remove = is_tick ? (fire && !rd_slot.repeats) : (rd_slot.ident == target_r);
    stall  = fire && pend_valid_r && !out_free;
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    cur_ms_nxt     = cur_ms_r;
    count_nxt      = count_r;
    fresh_nxt      = fresh_r;
    idx_nxt        = idx_r;
    keep_nxt       = keep_r;
    target_nxt     = target_r;
    resp_kind_nxt  = resp_kind_r;
    resp_id_nxt    = resp_id_r;
    pend_valid_nxt = pend_valid_r;
    pend_id_nxt    = pend_id_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_kind_nxt   = out_kind_r;
    out_id_nxt     = out_id_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = count_r[SLOT_W-1:0];
    ram_wdata      = '{ident: fresh_r, period: in_delay,
                       due_ms: cur_ms_r + {32'd0, in_delay}, repeats: in_periodic};
    ram_re         = 1'b0;
    ram_raddr      = '0;
    in_tready      = (state_r == ST_IDLE);

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          op_nxt     = in_tuser;
          target_nxt = in_target;
          idx_nxt    = '0;
          keep_nxt   = '0;
          case (in_tuser)
            OP_REG: begin
              state_nxt = ST_DONE;
              if (count_r == CNT_W'(TIMER_SLOTS)) begin
                resp_kind_nxt = KIND_FULL;
                resp_id_nxt   = '0;
              end else begin
                ram_we        = 1'b1;
                resp_kind_nxt = KIND_REGISTERED;
                resp_id_nxt   = fresh_r;
                count_nxt     = count_r + CNT_W'(1);
                fresh_nxt     = (fresh_inc == 32'd0) ? 32'd1 : fresh_inc;
              end
            end
            OP_UNREG: begin
              resp_kind_nxt = KIND_UNREG;
              resp_id_nxt   = '0;
              if (in_target != 32'd0 && count_r != '0) begin
                ram_re    = 1'b1;
                state_nxt = ST_SCAN;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            OP_TICK: begin
              cur_ms_nxt     = cur_ms_r + {48'd0, in_elapsed};
              pend_valid_nxt = 1'b0;
              if (count_r != '0) begin
                ram_re    = 1'b1;
                state_nxt = ST_SCAN;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (!stall) begin
          if (fire) begin
            // hold the newest fired id back until we know whether it is the last
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_FIRED;
              out_id_nxt    = pend_id_r;
              out_last_nxt  = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_id_nxt    = rd_slot.ident;
          end
          if (!remove) begin
            ram_we    = 1'b1;
            ram_waddr = keep_r[SLOT_W-1:0];
            ram_wdata = rd_slot;
            if (fire) begin
              ram_wdata.due_ms = rearm_due;
            end
            keep_nxt = keep_r + CNT_W'(1);
          end
          if (CNT_W'(idx_r) == count_r - CNT_W'(1)) begin
            count_nxt = remove ? keep_r : keep_r + CNT_W'(1);
            state_nxt = ST_DONE;
          end else begin
            idx_nxt   = idx_r + SLOT_W'(1);
            ram_re    = 1'b1;
            ram_raddr = idx_r + SLOT_W'(1);
          end
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (is_tick && pend_valid_r) begin
            out_kind_nxt = KIND_FIRED;
            out_id_nxt   = pend_id_r;
          end else if (is_tick) begin
            out_kind_nxt = KIND_IDLE;
            out_id_nxt   = '0;
          end else begin
            out_kind_nxt = resp_kind_r;
            out_id_nxt   = resp_id_r;
          end
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cur_ms_r     <= '0;
      count_r      <= '0;
      fresh_r      <= 32'd1;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_ms_r     <= cur_ms_nxt;
      count_r      <= count_nxt;
      fresh_r      <= fresh_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    idx_r       <= idx_nxt;
    keep_r      <= keep_nxt;
    target_r    <= target_nxt;
    resp_kind_r <= resp_kind_nxt;
    resp_id_r   <= resp_id_nxt;
    pend_id_r   <= pend_id_nxt;
    out_kind_r  <= out_kind_nxt;
    out_id_r    <= out_id_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_id_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== hdl/ltt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ltt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
